// ===== rtl/trapezoid_step_rate_generator_assert.svh =====
// ----------------------------------------------------------------------------
// trapezoid_step_rate_generator_assert
// assertion macros for the step rate generator
// ----------------------------------------------------------------------------
`ifndef TRAPEZOID_STEP_RATE_GENERATOR_ASSERT_SVH
`define TRAPEZOID_STEP_RATE_GENERATOR_ASSERT_SVH

// implication checked on every edge out of reset
`define TSRG_ASSERT_IMPL(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication checked on every edge out of reset
`define TSRG_ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ===== rtl/tsrg_pkg.sv =====
// ----------------------------------------------------------------------------
// tsrg_pkg
// shared types and constants of the trapezoid step rate generator
// ----------------------------------------------------------------------------
package tsrg_pkg;

    localparam logic [15:0] BAND8_RATE = 16'd19968;
    localparam logic [15:0] BAND4_RATE = 16'd9984;
    localparam logic [15:0] BAND2_RATE = 16'd4864;
    localparam logic [15:0] MIN_RATE   = 16'd32;
    localparam logic [15:0] MAX_STEP_RATE_RST = 16'd40000;

    localparam logic [1:0] PHASE_ACCEL  = 2'd0;
    localparam logic [1:0] PHASE_CRUISE = 2'd1;
    localparam logic [1:0] PHASE_DECEL  = 2'd2;
    localparam logic [1:0] PHASE_IDLE   = 2'd3;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef logic [3:0] loops_t;

endpackage

// ===== rtl/trapezoid_step_rate_generator.sv =====
// ----------------------------------------------------------------------------
// trapezoid_step_rate_generator
// trapezoid velocity profile step timer with a shared serial divider
// ----------------------------------------------------------------------------
// s_ channel: one transaction per load (op 0) or timer tick (op 1).
// m_ channel: one result transaction per input transaction.
// cfg channel: writes max_step_rate while the block is idle.
// a load computes one or two periods, each through a 24-step restoring
// divider (TICK_HZ / prescaled rate); the ramp product uses one 12x24
// multiplier in states S_MUL_LO and S_MUL_HI, one for each half of the
// elapsed time. a tick issues its step events in state S_STEP, one per
// cycle. the divider loop yields one quotient bit per cycle; the next item
// is accepted no earlier than the cycle after the result is taken.
// s_ready is low while an item is in work, while a result waits on m_ and
// while a cfg transaction is offered.
// a stalled receiver holds the result and blocks the next item.
// reset clears the block state, sets max_step_rate to 40000 and leaves
// the block idle; an idle tick returns IDLE_PERIOD.
// ----------------------------------------------------------------------------
`include "trapezoid_step_rate_generator_assert.svh"

module trapezoid_step_rate_generator
    import tsrg_pkg::*;
#(
    parameter int TICK_HZ     = 2000000,
    parameter int IDLE_PERIOD = 2000
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [15:0] s_initial_rate,
    input  logic [15:0] s_nominal_rate,
    input  logic [15:0] s_final_rate,
    input  logic [31:0] s_accel_until,
    input  logic [31:0] s_decel_after,
    input  logic [23:0] s_accel_factor,
    input  logic [31:0] s_total_steps,
    input  logic        s_use_ramp,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_timer_period,
    output logic [3:0]  m_steps_taken,
    output logic [1:0]  m_phase,
    output logic        m_block_done
);

    localparam int DW = 24;
    localparam logic [DW-1:0] TICK_C = DW'(TICK_HZ);
    localparam logic [15:0] IDLE_C = 16'(IDLE_PERIOD);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD_NOM, S_LOAD_RAMP, S_STEP, S_MUL_LO, S_MUL_HI,
        S_RATE, S_DIV_START, S_DIV, S_FINISH, S_OUT
    } state_t;

    typedef enum logic [1:0] {
        D_CRUISE, D_START, D_TICK
    } dest_t;

    state_t state_reg;
    dest_t  dest_reg;

    logic [15:0] max_rate_reg;
    logic        active_reg;
    logic [31:0] events_reg, accel_time_reg, decel_time_reg;
    logic [15:0] ramp_rate_reg, cruise_period_reg;
    loops_t      loops_now_reg, loops_cruise_reg;
    logic [15:0] initial_reg, nominal_reg, final_reg;
    logic [31:0] accel_until_reg, decel_after_reg, total_reg;
    logic [23:0] factor_reg;
    logic        use_ramp_reg;

    logic [3:0]  step_cnt_reg;
    logic [1:0]  phase_reg;
    logic [47:0] prod_reg;
    logic [15:0] rate_reg;
    loops_t      loops_calc_reg;

    // divider
    logic [DW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [15:0]   dvs_reg;
    logic [4:0]    dcnt_reg;
    logic          dzero_reg;

    logic [15:0] out_period_reg;
    logic [3:0]  out_steps_reg;
    logic [1:0]  out_phase_reg;
    logic        out_done_reg;

    // prescaling of a rate
    logic [15:0] pre_r;
    loops_t      pre_loops;
    always_comb begin
        if (rate_reg[15:8] > BAND8_RATE[15:8]) begin
            if (rate_reg[15:8] > max_rate_reg[15:8]) begin
                pre_r = {3'd0, max_rate_reg[15:3]};
            end else begin
                pre_r = {3'd0, rate_reg[15:3]};
            end
            pre_loops = 4'd8;
        end else if (rate_reg[15:8] > BAND4_RATE[15:8]) begin
            pre_r = {2'd0, rate_reg[15:2]};
            pre_loops = 4'd4;
        end else if (rate_reg[15:8] > BAND2_RATE[15:8]) begin
            pre_r = {1'd0, rate_reg[15:1]};
            pre_loops = 4'd2;
        end else begin
            pre_r = (rate_reg < MIN_RATE) ? MIN_RATE : rate_reg;
            pre_loops = 4'd1;
        end
    end

    // one restoring step
    logic [DW:0]   trial;
    logic [DW-1:0] rem_sh;
    always_comb begin
        rem_sh = {rem_reg[DW-2:0], quo_reg[DW-1]};
        trial  = {1'b0, rem_sh} - {{(DW-15){1'b0}}, dvs_reg};
    end

    logic [15:0] div_result;
    always_comb begin
        if (dzero_reg || (quo_reg[DW-1:16] != '0)) begin
            div_result = 16'hFFFF;
        end else begin
            div_result = quo_reg[15:0];
        end
    end

    logic [15:0] prod_rnd;
    assign prod_rnd = 16'((prod_reg + 48'h800000) >> 24);

    logic [31:0] ev_inc;
    assign ev_inc = events_reg + 32'd1;

    logic [23:0] t_sel;
    assign t_sel = (phase_reg == PHASE_ACCEL) ? accel_time_reg[23:0] : decel_time_reg[23:0];

    // shared partial product, low half of the time first
    logic [11:0] mul_a;
    logic [35:0] mul_p;
    assign mul_a = (state_reg == S_MUL_LO) ? t_sel[11:0] : t_sel[23:12];
    assign mul_p = {24'd0, mul_a} * {12'd0, factor_reg};

    assign s_ready   = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_valid   = (state_reg == S_OUT);
    assign m_timer_period = out_period_reg;
    assign m_steps_taken  = out_steps_reg;
    assign m_phase        = out_phase_reg;
    assign m_block_done   = out_done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            dest_reg         <= D_CRUISE;
            max_rate_reg     <= MAX_STEP_RATE_RST;
            active_reg       <= 1'b0;
            events_reg       <= '0;
            accel_time_reg   <= '0;
            decel_time_reg   <= '0;
            ramp_rate_reg    <= '0;
            loops_now_reg    <= 4'd1;
            loops_cruise_reg <= 4'd1;
            cruise_period_reg <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (cfg_valid) begin
                        max_rate_reg <= cfg_data;
                    end
                    if (s_valid && !cfg_valid) begin
                        out_steps_reg <= '0;
                        out_phase_reg <= PHASE_IDLE;
                        out_done_reg  <= 1'b0;
                        step_cnt_reg  <= '0;
                        if (s_op == OP_LOAD) begin
                            initial_reg     <= s_initial_rate;
                            nominal_reg     <= s_nominal_rate;
                            final_reg       <= s_final_rate;
                            accel_until_reg <= s_accel_until;
                            decel_after_reg <= s_decel_after;
                            factor_reg      <= s_accel_factor;
                            total_reg       <= s_total_steps;
                            use_ramp_reg    <= s_use_ramp;
                            active_reg      <= 1'b1;
                            events_reg      <= '0;
                            decel_time_reg  <= '0;
                            rate_reg        <= s_nominal_rate;
                            dest_reg        <= D_CRUISE;
                            state_reg       <= S_DIV_START;
                        end else if (active_reg) begin
                            state_reg <= S_STEP;
                        end else begin
                            out_period_reg <= IDLE_C;
                            state_reg      <= S_OUT;
                        end
                    end
                end
                S_LOAD_RAMP: begin
                    if (use_ramp_reg) begin
                        ramp_rate_reg <= initial_reg;
                        rate_reg      <= initial_reg;
                        dest_reg      <= D_START;
                        state_reg     <= S_DIV_START;
                    end else begin
                        out_period_reg <= cruise_period_reg;
                        state_reg      <= S_OUT;
                    end
                end
                S_STEP: begin
                    // one step event per cycle
                    events_reg   <= ev_inc;
                    step_cnt_reg <= step_cnt_reg + 4'd1;
                    if ((ev_inc >= total_reg) ||
                        ((step_cnt_reg + 4'd1) == loops_now_reg)) begin
                        state_reg <= S_MUL_LO;
                        if (ev_inc <= accel_until_reg) begin
                            phase_reg <= PHASE_ACCEL;
                        end else if (ev_inc > decel_after_reg) begin
                            phase_reg <= PHASE_DECEL;
                        end else begin
                            phase_reg <= PHASE_CRUISE;
                        end
                    end
                end
                S_MUL_LO: begin
                    out_steps_reg <= step_cnt_reg;
                    out_phase_reg <= phase_reg;
                    out_done_reg  <= (events_reg >= total_reg);
                    if (events_reg >= total_reg) begin
                        active_reg <= 1'b0;
                    end
                    if (phase_reg == PHASE_CRUISE) begin
                        out_period_reg <= cruise_period_reg;
                        loops_now_reg  <= loops_cruise_reg;
                        state_reg      <= S_OUT;
                    end else begin
                        prod_reg  <= {12'd0, mul_p};
                        state_reg <= S_MUL_HI;
                    end
                end
                S_MUL_HI: begin
                    prod_reg  <= prod_reg + {mul_p, 12'd0};
                    state_reg <= S_RATE;
                end
                S_RATE: begin
                    dest_reg  <= D_TICK;
                    state_reg <= S_DIV_START;
                    if (phase_reg == PHASE_ACCEL) begin
                        if ((prod_rnd + initial_reg) > nominal_reg) begin
                            rate_reg      <= nominal_reg;
                            ramp_rate_reg <= nominal_reg;
                        end else begin
                            rate_reg      <= prod_rnd + initial_reg;
                            ramp_rate_reg <= prod_rnd + initial_reg;
                        end
                    end else if (prod_rnd > ramp_rate_reg) begin
                        rate_reg <= final_reg;
                    end else if ((ramp_rate_reg - prod_rnd) < final_reg) begin
                        rate_reg <= final_reg;
                    end else begin
                        rate_reg <= ramp_rate_reg - prod_rnd;
                    end
                end
                S_DIV_START: begin
                    quo_reg        <= TICK_C;
                    rem_reg        <= '0;
                    dvs_reg        <= pre_r;
                    dzero_reg      <= (pre_r == '0);
                    loops_calc_reg <= pre_loops;
                    dcnt_reg       <= 5'(DW);
                    state_reg      <= S_DIV;
                end
                S_DIV: begin
                    if (trial[DW]) begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[DW-2:0], 1'b0};
                    end else begin
                        rem_reg <= trial[DW-1:0];
                        quo_reg <= {quo_reg[DW-2:0], 1'b1};
                    end
                    dcnt_reg <= dcnt_reg - 5'd1;
                    if (dcnt_reg == 5'd1) begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    case (dest_reg)
                        D_CRUISE: begin
                            cruise_period_reg <= div_result;
                            loops_cruise_reg  <= loops_calc_reg;
                            loops_now_reg     <= loops_calc_reg;
                            state_reg         <= S_LOAD_RAMP;
                        end
                        D_START: begin
                            loops_now_reg  <= loops_calc_reg;
                            accel_time_reg <= {16'd0, div_result};
                            out_period_reg <= div_result;
                            state_reg      <= S_OUT;
                        end
                        default: begin
                            loops_now_reg  <= loops_calc_reg;
                            out_period_reg <= div_result;
                            if (phase_reg == PHASE_ACCEL) begin
                                accel_time_reg <= accel_time_reg + {16'd0, div_result};
                            end else begin
                                decel_time_reg <= decel_time_reg + {16'd0, div_result};
                            end
                            state_reg <= S_OUT;
                        end
                    endcase
                end
                S_OUT: begin
                    if (m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `TSRG_ASSERT_IMPL(a_ready_only_idle, aclk, aresetn, s_ready, !m_valid)
    `TSRG_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_timer_period))
    `TSRG_ASSERT_IMPL(a_steps_range, aclk, aresetn, m_valid, m_steps_taken <= 4'd8)
    `TSRG_ASSERT_IMPL(a_done_ends, aclk, aresetn, m_valid && m_block_done, !active_reg)

endmodule
